// File: design/cbf_pkg.sv
// Shared types, constants and blend function of the canvas blend engine.
package cbf_pkg;

  localparam int unsigned CoordW = 9;
  localparam int unsigned PixW   = 32;

  typedef enum logic [1:0] {
    CMD_FILL = 2'd0,
    CMD_LINE = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINE_MUL,
    ST_LINE_DIV,
    ST_LINE_POS,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_READ_RD,
    ST_READ_OUT
  } state_e;

  // per channel (s*a + d*(255-a)) >> 8, alpha forced opaque
  function automatic logic [PixW-1:0] mix_pixel(input logic [PixW-1:0] src,
                                                input logic [PixW-1:0] dst,
                                                input logic [7:0] a);
    logic [PixW-1:0] res;
    logic [16:0]     acc;
    logic [7:0]      na;
    res = 32'hFF00_0000;
    na  = 8'hFF - a;
    for (int ch = 0; ch < 3; ch++) begin
      acc = 17'(src[ch*8 +: 8] * a) + 17'(dst[ch*8 +: 8] * na);
      res[ch*8 +: 8] = acc[15:8];
    end
    return res;
  endfunction

endpackage

// File: design/cbf_ram.sv
// Generic simple dual-port RAM with registered read.
module cbf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: design/canvas_blend_fill_and_aa_line.sv
// Canvas blend engine: alpha-blended rectangle fill, anti-aliased line and pixel read over
// an ARGB8888 canvas held in one synchronous RAM of MAX_WIDTH*MAX_HEIGHT words. Pixel (x,y)
// lives at word y*W+x, W the canvas width in use. After reset the canvas is swept to zero,
// one word a cycle; commands are held off meanwhile while register writes are taken.
// Commands run one at a time. Every pixel is a read-modify-write through the single RAM
// read and write port: a read state, then a write state. A line takes, per column, a
// multiply step, the bit-serial divider that yields row and coverage, a position step and
// the pixel updates (two rows when coverage is fractional). A read delivers one
// transaction on the output channel, which is held in an output register; a further read
// waits for that slot to free.
module canvas_blend_fill_and_aa_line
  import cbf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [8:0]  x_a_i,
  input  logic [8:0]  y_a_i,
  input  logic [7:0]  x_b_i,
  input  logic [7:0]  y_b_i,
  input  logic [8:0]  rect_width_i,
  input  logic [8:0]  rect_height_i,
  input  logic [31:0] color_i,
  // read result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        read_in_range_o,
  // register port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);

  // ---------------------------------------------------------------- registers
  logic [8:0] cfg_w_q, cfg_h_q;
  logic [8:0] eff_w, eff_h;
  logic       cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= 9'd256;
      cfg_h_q <= 9'd256;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr_i[2]))
        REG_WIDTH:  cfg_w_q <= pwdata_i[8:0];
        REG_HEIGHT: cfg_h_q <= pwdata_i[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr_i[2]))
      REG_WIDTH:  prdata_o = {23'd0, cfg_w_q};
      REG_HEIGHT: prdata_o = {23'd0, cfg_h_q};
      default:    prdata_o = '0;
    endcase
  end

  // saturate to the store's shape
  assign eff_w = (32'(cfg_w_q) > MAX_WIDTH)  ? 9'(MAX_WIDTH)  : cfg_w_q;
  assign eff_h = (32'(cfg_h_q) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : cfg_h_q;

  // ---------------------------------------------------------------- state
  state_e st_q, st_d;
  logic [1:0]  cmd_q, cmd_d;
  logic [31:0] color_q, color_d;
  logic [AW-1:0] clr_q, clr_d;

  // current pixel
  logic [8:0]         px_x_q, px_x_d;
  logic signed [10:0] px_y_q, px_y_d;
  logic [7:0]         px_a_q, px_a_d;
  logic               px_sel_q, px_sel_d;   // second row of a line column

  // fill bounds
  logic [9:0] fx0_q, fx0_d, fxe_q, fxe_d, fye_q, fye_d;

  // line stepping
  logic [8:0]         ln_sy_q, ln_sy_d, ln_ex_q, ln_ex_d, ln_dx_q, ln_dx_d;
  logic [8:0]         ln_ady_q, ln_ady_d, ln_k_q, ln_k_d;
  logic               ln_neg_q, ln_neg_d, ln_up_q, ln_up_d;
  logic signed [10:0] ln_y0_q, ln_y0_d;
  logic [7:0]         ln_frac_q, ln_frac_d;

  // bit-serial divider
  logic [25:0] div_n_q, div_n_d;
  logic [8:0]  div_r_q, div_r_d;
  logic [4:0]  div_cnt_q, div_cnt_d;

  // output slot
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;
  logic        out_rng_q, out_rng_d;

  // ---------------------------------------------------------------- memory
  logic          ram_we;
  logic [AW-1:0] ram_waddr, px_addr;
  logic [31:0]   ram_wdata, ram_rdata;
  logic          px_inside;
  logic [17:0]   px_prod;

  assign px_inside = !px_y_q[10] && (px_y_q[9:0] < {1'b0, eff_h}) && (px_x_q < eff_w);
  assign px_prod   = px_y_q[8:0] * eff_w + 18'(px_x_q);
  assign px_addr   = AW'(px_prod);

  cbf_ram #(
    .WIDTH(32),
    .DEPTH(Depth)
  ) u_canvas (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(px_addr),
    .rdata_o(ram_rdata)
  );

  // ---------------------------------------------------------------- datapath helpers
  logic        acc;
  logic        swap;
  logic [8:0]  a_sx, a_sy, a_ex, a_ey;
  logic signed [9:0] a_dy;
  logic [9:0]  rw_c, rh_c;
  logic [17:0] ln_p;
  logic [9:0]  div_trial;
  logic        div_bit;
  logic [8:0]  ln_q;

  assign acc  = in_valid_i & ~in_stall_o;
  assign swap = x_a_i > {1'b0, x_b_i};
  assign a_sx = swap ? {1'b0, x_b_i} : x_a_i;
  assign a_sy = swap ? {1'b0, y_b_i} : y_a_i;
  assign a_ex = swap ? x_a_i : {1'b0, x_b_i};
  assign a_ey = swap ? y_a_i : {1'b0, y_b_i};
  assign a_dy = $signed({1'b0, a_ey}) - $signed({1'b0, a_sy});

  // fill clipping
  assign rw_c = ({1'b0, rect_width_i} + {1'b0, x_a_i} > {1'b0, eff_w})
              ? ({1'b0, eff_w} - {1'b0, x_a_i}) : {1'b0, rect_width_i};
  assign rh_c = ({1'b0, rect_height_i} + {1'b0, y_a_i} > {1'b0, eff_h})
              ? ({1'b0, eff_h} - {1'b0, y_a_i}) : {1'b0, rect_height_i};

  assign ln_p      = ln_ady_q * ln_k_q;
  assign div_trial = {div_r_q, div_n_q[25]};
  assign div_bit   = div_trial >= {1'b0, ln_dx_q};
  assign ln_q      = div_n_q[16:8];

  assign in_stall_o      = (st_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_data_q;
  assign read_in_range_o = out_rng_q;

  // ---------------------------------------------------------------- control
  always_comb begin
    st_d        = st_q;
    cmd_d       = cmd_q;
    color_d     = color_q;
    clr_d       = clr_q;
    px_x_d      = px_x_q;
    px_y_d      = px_y_q;
    px_a_d      = px_a_q;
    px_sel_d    = px_sel_q;
    fx0_d       = fx0_q;
    fxe_d       = fxe_q;
    fye_d       = fye_q;
    ln_sy_d     = ln_sy_q;
    ln_ex_d     = ln_ex_q;
    ln_dx_d     = ln_dx_q;
    ln_ady_d    = ln_ady_q;
    ln_k_d      = ln_k_q;
    ln_neg_d    = ln_neg_q;
    ln_up_d     = ln_up_q;
    ln_y0_d     = ln_y0_q;
    ln_frac_d   = ln_frac_q;
    div_n_d     = div_n_q;
    div_r_d     = div_r_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;
    out_rng_d   = out_rng_q;
    ram_we      = 1'b0;
    ram_waddr   = px_addr;
    ram_wdata   = mix_pixel(color_q, ram_rdata, px_a_q);

    unique case (st_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (32'(clr_q) == Depth - 1) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          cmd_d   = cmd_i;
          color_d = color_i;
          case (cmd_e'(cmd_i))
            CMD_FILL: begin
              px_a_d = color_i[31:24];
              px_x_d = x_a_i;
              px_y_d = $signed({2'b0, y_a_i});
              fx0_d  = {1'b0, x_a_i};
              fxe_d  = {1'b0, x_a_i} + rw_c;
              fye_d  = {1'b0, y_a_i} + rh_c;
              if (x_a_i <= eff_w && y_a_i <= eff_h && rw_c != '0 && rh_c != '0)
                st_d = ST_PIX_RD;
            end
            CMD_LINE: begin
              px_x_d   = a_sx;
              ln_sy_d  = a_sy;
              ln_ex_d  = a_ex;
              ln_dx_d  = a_ex - a_sx;
              ln_ady_d = a_dy[9] ? 9'(-a_dy) : a_dy[8:0];
              ln_neg_d = a_dy[9];
              ln_up_d  = !a_dy[9] && a_dy != '0;
              ln_k_d   = '0;
              if (a_ex != a_sx) st_d = ST_LINE_MUL;
            end
            CMD_READ: begin
              px_x_d = x_a_i;
              px_y_d = $signed({2'b0, y_a_i});
              st_d   = ST_READ_RD;
            end
            default: ;
          endcase
        end
      end
      ST_LINE_MUL: begin
        // numerator |p| * 256: quotient high part is the row step, low byte the coverage
        div_n_d   = {ln_p, 8'd0};
        div_r_d   = '0;
        div_cnt_d = '0;
        st_d      = ST_LINE_DIV;
      end
      ST_LINE_DIV: begin
        div_r_d   = div_bit ? 9'(div_trial - {1'b0, ln_dx_q}) : div_trial[8:0];
        div_n_d   = {div_n_q[24:0], div_bit};
        div_cnt_d = div_cnt_q + 5'd1;
        if (div_cnt_q == 5'd25) st_d = ST_LINE_POS;
      end
      ST_LINE_POS: begin
        ln_y0_d   = ln_neg_q ? ($signed({2'b0, ln_sy_q}) - $signed({2'b0, ln_q}))
                             : ($signed({2'b0, ln_sy_q}) + $signed({2'b0, ln_q}));
        ln_frac_d = div_n_q[7:0];
        px_y_d    = ln_y0_d;
        px_a_d    = ~div_n_q[7:0];
        px_sel_d  = 1'b0;
        st_d      = ST_PIX_RD;
      end
      ST_PIX_RD: begin
        st_d = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        ram_we = px_inside;
        if (cmd_e'(cmd_q) == CMD_FILL) begin
          if ({1'b0, px_x_q} + 10'd1 == fxe_q) begin
            px_x_d = fx0_q[8:0];
            px_y_d = px_y_q + 11'sd1;
            if (px_y_q[9:0] + 10'd1 == fye_q) st_d = ST_IDLE;
            else st_d = ST_PIX_RD;
          end else begin
            px_x_d = px_x_q + 9'd1;
            st_d   = ST_PIX_RD;
          end
        end else if (!px_sel_q && ln_frac_q != '0) begin
          // neighbouring row takes the complementary weight
          px_sel_d = 1'b1;
          px_y_d   = ln_up_q ? ln_y0_q + 11'sd1 : ln_y0_q - 11'sd1;
          px_a_d   = ln_frac_q;
          st_d     = ST_PIX_RD;
        end else begin
          px_x_d = px_x_q + 9'd1;
          ln_k_d = ln_k_q + 9'd1;
          if (px_x_q + 9'd1 == ln_ex_q) st_d = ST_IDLE;
          else st_d = ST_LINE_MUL;
        end
      end
      ST_READ_RD: begin
        if (!out_valid_q) st_d = ST_READ_OUT;
      end
      ST_READ_OUT: begin
        out_valid_d = 1'b1;
        out_data_d  = px_inside ? ram_rdata : '0;
        out_rng_d   = px_inside;
        st_d        = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    color_q   <= color_d;
    px_x_q    <= px_x_d;
    px_y_q    <= px_y_d;
    px_a_q    <= px_a_d;
    px_sel_q  <= px_sel_d;
    fx0_q     <= fx0_d;
    fxe_q     <= fxe_d;
    fye_q     <= fye_d;
    ln_sy_q   <= ln_sy_d;
    ln_ex_q   <= ln_ex_d;
    ln_dx_q   <= ln_dx_d;
    ln_ady_q  <= ln_ady_d;
    ln_k_q    <= ln_k_d;
    ln_neg_q  <= ln_neg_d;
    ln_up_q   <= ln_up_d;
    ln_y0_q   <= ln_y0_d;
    ln_frac_q <= ln_frac_d;
    div_n_q   <= div_n_d;
    div_r_q   <= div_r_d;
    div_cnt_q <= div_cnt_d;
    out_data_q <= out_data_d;
    out_rng_q  <= out_rng_d;
  end

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the canvas blend engine: fill, line and read transactions.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cbf_pkg::*;

  localparam int unsigned Depth = 256 * 256;
  // clearing sweep, full-canvas fills and ~140 commands of up to 256 line columns each
  localparam longint unsigned CycleLimit = 20_000_000;

  typedef struct {
    cmd_e        cmd;
    logic [8:0]  xa, ya;
    logic [7:0]  xb, yb;
    logic [8:0]  rw, rh;
    logic [31:0] color;
  } draw_cmd_t;

  typedef struct {
    logic [31:0] data;
    logic        in_range;
  } pixel_read_t;

  // Canvas mirror plus queue of expected pixel reads.
  class canvas_scoreboard;
    logic [31:0] pixels [Depth];
    int unsigned width_reg, height_reg;
    pixel_read_t reads_due [$];
    int errors;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      width_reg  = 256;
      height_reg = 256;
      errors     = 0;
    endfunction

    function int unsigned canvas_w();
      return width_reg > 256 ? 256 : width_reg;
    endfunction

    function int unsigned canvas_h();
      return height_reg > 256 ? 256 : height_reg;
    endfunction

    function logic [31:0] blend(logic [31:0] src, logic [31:0] dst, int unsigned a);
      logic [31:0] res;
      int unsigned acc;
      res = 32'hFF00_0000;
      a   = a & 8'hFF;
      for (int ch = 0; ch < 3; ch++) begin
        acc = src[ch*8 +: 8] * a + dst[ch*8 +: 8] * (255 - a);
        res[ch*8 +: 8] = acc[15:8];
      end
      return res;
    endfunction

    function void paint(int x, int y, logic [31:0] color, int unsigned a);
      int unsigned w, h, idx;
      w = canvas_w();
      h = canvas_h();
      if (x < 0 || y < 0 || x >= int'(w) || y >= int'(h)) return;
      idx = y * w + x;
      if (idx >= Depth) return;
      pixels[idx] = blend(color, pixels[idx], a);
    endfunction

    function void fill_rect(draw_cmd_t c);
      int unsigned w, h, rw, rh;
      w  = canvas_w();
      h  = canvas_h();
      rw = c.rw;
      rh = c.rh;
      if (c.xa > w || c.ya > h) return;
      if (rw + c.xa > w) rw = w - c.xa;
      if (rh + c.ya > h) rh = h - c.ya;
      for (int i = 0; i < rh; i++)
        for (int j = 0; j < rw; j++)
          paint(c.xa + j, c.ya + i, c.color, c.color[31:24]);
    endfunction

    function void draw_line(draw_cmd_t c);
      int sx, sy, ex, ey, dx, dy, step, p, y, frac;
      if (int'(c.xa) > int'(c.xb)) begin
        sx = c.xb; sy = c.yb; ex = c.xa; ey = c.ya;
      end else begin
        sx = c.xa; sy = c.ya; ex = c.xb; ey = c.yb;
      end
      dx   = ex - sx;
      dy   = ey - sy;
      step = dy > 0 ? 1 : -1;
      for (int x = sx; x < ex; x++) begin
        p    = dy * (x - sx);
        y    = p / dx + sy;
        frac = ((p % dx) * 256) / dx;
        if (frac < 0) frac = -frac;
        paint(x, y, c.color, 255 - frac);
        if (frac != 0) paint(x, y + step, c.color, frac);
      end
    endfunction

    function void note_cmd(draw_cmd_t c);
      int unsigned w, h, idx;
      pixel_read_t r;
      case (c.cmd)
        CMD_FILL: fill_rect(c);
        CMD_LINE: draw_line(c);
        CMD_READ: begin
          w   = canvas_w();
          h   = canvas_h();
          idx = c.ya * w + c.xa;
          if (c.xa < w && c.ya < h && idx < Depth) begin
            r.data = pixels[idx]; r.in_range = 1'b1;
          end else begin
            r.data = '0; r.in_range = 1'b0;
          end
          reads_due.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_read(logic [31:0] data, logic in_range);
      pixel_read_t r;
      if (reads_due.size() == 0) begin
        report("unexpected read transaction", data, '0);
        return;
      end
      r = reads_due.pop_front();
      if (data !== r.data) report("read_data", data, r.data);
      if (in_range !== r.in_range) report("read_in_range", 32'(in_range), 32'(r.in_range));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = '0;
  logic [8:0]  x_a_i = '0, y_a_i = '0, rect_width_i = '0, rect_height_i = '0;
  logic [7:0]  x_b_i = '0, y_b_i = '0;
  logic [31:0] color_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] read_data_o;
  logic        read_in_range_o;
  logic        psel_i = 1'b0, penable_i = 1'b0, pwrite_i = 1'b0;
  logic [2:0]  paddr_i = '0;
  logic [31:0] pwdata_i = '0;
  logic [31:0] prdata_o;
  logic        pready_o;

  canvas_blend_fill_and_aa_line dut (.*);

  always #1 clk_i = ~clk_i;

  canvas_scoreboard sb = new();
  bit               idle_on = 1'b1;   // random gaps enabled on both channels
  longint unsigned  cycles = 0;
  int unsigned      last_x = 0, last_y = 0;   // recent drawing point, aimed at by reads

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // read channel check, sampled at the rising edge
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_read(read_data_o, read_in_range_o);

  // receiver stalls, changed at the falling edge
  always @(negedge clk_i)
    out_stall_i <= idle_on && ($urandom_range(99) < 30);

  task automatic reg_write(reg_e which, logic [8:0] value);
    psel_i    <= 1'b1;
    pwrite_i  <= 1'b1;
    penable_i <= 1'b0;
    paddr_i   <= 3'(which) << 2;
    pwdata_i  <= 32'(value);
    @(negedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    if (which == REG_WIDTH) sb.width_reg = 32'(value);
    else sb.height_reg = 32'(value);
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    @(negedge clk_i);
  endtask

  // one command transaction; entered and left at a falling edge, valid at times dropped for a random gap
  task automatic send(draw_cmd_t c);
    in_valid_i    <= 1'b1;
    cmd_i         <= c.cmd;
    x_a_i         <= c.xa;
    y_a_i         <= c.ya;
    x_b_i         <= c.xb;
    y_b_i         <= c.yb;
    rect_width_i  <= c.rw;
    rect_height_i <= c.rh;
    color_i       <= c.color;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_cmd(c);
    @(negedge clk_i);
    if (idle_on && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  function automatic draw_cmd_t mk(cmd_e cmd, int xa, int ya, int xb, int yb,
                                   int rw, int rh, logic [31:0] color);
    draw_cmd_t c;
    c.cmd = cmd; c.xa = 9'(xa); c.ya = 9'(ya); c.xb = 8'(xb); c.yb = 8'(yb);
    c.rw = 9'(rw); c.rh = 9'(rh); c.color = color;
    return c;
  endfunction

  // read transaction then wait for all reads; the read only completes once prior
  // drawing is done, so the block is idle afterwards
  task automatic settle();
    send(mk(CMD_READ, last_x, last_y, 0, 0, 0, 0, '0));
    in_valid_i <= 1'b0;
    while (sb.reads_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t   c;
    int unsigned w, h, pick, big;
    w    = sb.canvas_w();
    h    = sb.canvas_h();
    big  = (w * h <= 4096);
    pick = $urandom_range(99);
    c = mk(CMD_NONE, $urandom_range(256), $urandom_range(256), $urandom_range(255),
           $urandom_range(255), $urandom_range(256), $urandom_range(256), $urandom());
    case ($urandom_range(9))
      0: c.color[31:24] = 8'h00;
      1: c.color[31:24] = 8'hFF;
      default: ;
    endcase
    if (pick < 35) begin
      c.cmd = CMD_FILL;
      if ($urandom_range(9) != 0) begin
        c.xa = 9'($urandom_range(w));
        c.ya = 9'($urandom_range(h));
      end
      if (!big) begin
        c.rw = 9'($urandom_range(12));
        c.rh = 9'($urandom_range(12));
      end
      last_x = 32'(c.xa); last_y = 32'(c.ya);
    end else if (pick < 65) begin
      c.cmd = CMD_LINE;
      if ($urandom_range(3) != 0) begin
        // mostly short lines over the canvas in use
        c.xa = 9'($urandom_range(w));
        c.ya = 9'($urandom_range(h));
        c.xb = 8'(int'($urandom_range(c.xa > 40 ? c.xa - 40 : 0,
                                      c.xa + 40 > 255 ? 255 : c.xa + 40)));
        c.yb = 8'($urandom_range(h > 255 ? 255 : h));
      end
      last_x = 32'(c.xb); last_y = 32'(c.yb);
    end else if (pick < 95) begin
      c.cmd = CMD_READ;
      if ($urandom_range(9) < 6) begin
        c.xa = 9'(last_x + $urandom_range(1));
        c.ya = 9'(last_y);
      end
    end
    return c;
  endfunction

  initial begin
    draw_cmd_t   c;
    int unsigned phase_w [6] = '{64, 1, 256, 511, 37, 256};
    int unsigned phase_h [6] = '{48, 256, 1, 0, 200, 256};
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    // registers are taken during the clearing sweep
    reg_write(REG_WIDTH, 9'd256);
    reg_write(REG_HEIGHT, 9'd256);

    // directed: corners, extremes and special cases
    send(mk(CMD_READ, 0, 0, 0, 0, 0, 0, '0));                  // cleared canvas
    send(mk(CMD_FILL, 0, 0, 0, 0, 256, 256, 32'h80FF_00FF));   // whole canvas
    send(mk(CMD_READ, 255, 255, 0, 0, 0, 0, '0));
    send(mk(CMD_FILL, 250, 250, 0, 0, 511, 511, 32'hFF12_3456)); // clipped at both edges
    send(mk(CMD_FILL, 256, 10, 0, 0, 4, 4, 32'hFFFF_FFFF));      // start on the edge
    send(mk(CMD_FILL, 300, 300, 0, 0, 4, 4, 32'hFFFF_FFFF));     // start outside
    send(mk(CMD_FILL, 3, 3, 0, 0, 0, 5, 32'hFFFF_FFFF));         // zero width
    send(mk(CMD_FILL, 5, 5, 0, 0, 2, 2, 32'h00AB_CDEF));         // transparent
    send(mk(CMD_READ, 5, 5, 0, 0, 0, 0, '0));
    send(mk(CMD_LINE, 10, 20, 10, 200, 0, 0, 32'hFFFF_FFFF));    // vertical: nothing
    send(mk(CMD_LINE, 0, 0, 255, 255, 0, 0, 32'hFF00_FF00));     // diagonal
    send(mk(CMD_LINE, 40, 10, 0, 17, 0, 0, 32'hC0FF_0000));      // reversed, fractional
    send(mk(CMD_LINE, 256, 256, 200, 0, 0, 0, 32'hFF0F_F0F0));   // starts off canvas
    send(mk(CMD_LINE, 20, 255, 30, 0, 0, 0, 32'h7F00_00FF));     // steep descent
    send(mk(CMD_READ, 39, 11, 0, 0, 0, 0, '0));
    send(mk(CMD_READ, 21, 230, 0, 0, 0, 0, '0));
    send(mk(CMD_READ, 256, 0, 0, 0, 0, 0, '0));                 // outside in x
    send(mk(CMD_READ, 0, 256, 0, 0, 0, 0, '0));                 // outside in y
    send(mk(CMD_NONE, 511, 511, 255, 255, 511, 511, '1));       // unused code
    send(mk(CMD_READ, 255, 0, 0, 0, 0, 0, '0));
    last_x = 7; last_y = 7;
    settle();

    foreach (phase_w[p]) begin
      reg_write(REG_WIDTH, 9'(phase_w[p]));
      reg_write(REG_HEIGHT, 9'(phase_h[p]));
      idle_on = (p != 2);   // one phase runs without any gaps
      for (int i = 0; i < 20; i++) begin
        c = random_cmd();
        send(c);
      end
      settle();
    end

    in_valid_i <= 1'b0;
    while (sb.reads_due.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (sb.errors == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
